/* rtl/tss_pkg.sv */
// Package for the twin stack shared store unit.
// Holds operation and status codes, the controller/datapath command and status structs,
// and default sizes. No dependencies.
package tss_pkg;

    localparam int DATA_W            = 32;
    localparam int OP_W              = 3;
    localparam int STATUS_W          = 2;
    localparam int STORE_DEPTH_DEF   = 16;

    // Operation codes carried by an input item
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FIRST  = 3'd0,
        OP_PUSH_SECOND = 3'd1,
        OP_POP_FIRST   = 3'd2,
        OP_POP_SECOND  = 3'd3,
        OP_LIST_FIRST  = 3'd4,
        OP_LIST_SECOND = 3'd5
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE      = 2'd0,
        S_POP_DATA  = 2'd1,
        S_LIST_DATA = 2'd2
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    push_first;
        logic    push_second;
        logic    pop_first;
        logic    pop_second;
        logic    list_first;
        logic    list_second;
        logic    list_next;
        logic    load;
        status_t resp_status;
        logic    resp_mem;
        logic    resp_last;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic first_empty;
        logic second_empty;
        logic cursor_end;
        logic out_free;
    } stat_t;

endpackage

/* rtl/tss_ctrl.sv */
// Controller state machine for the twin stack shared store unit.
// Decodes items, sequences pops and lists, drives datapath commands. Uses tss_pkg.
module tss_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tss_pkg::OP_W-1:0]    operation,
    input  tss_pkg::stat_t              stat,
    output tss_pkg::cmd_t               cmd
);
    import tss_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // Items enter only when idle and the result register can take a value
    assign in_stall = !((state_reg == S_IDLE) && stat.out_free);
    assign accept   = in_valid && !in_stall;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next      = state_reg;
        cmd.push_first  = 1'b0;
        cmd.push_second = 1'b0;
        cmd.pop_first   = 1'b0;
        cmd.pop_second  = 1'b0;
        cmd.list_first  = 1'b0;
        cmd.list_second = 1'b0;
        cmd.list_next   = 1'b0;
        cmd.load        = 1'b0;
        cmd.resp_status = ST_OK;
        cmd.resp_mem    = 1'b0;
        cmd.resp_last   = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(operation))
                        OP_PUSH_FIRST:
                        begin
                            cmd.load = 1'b1;
                            if (stat.full)
                                cmd.resp_status = ST_FULL;
                            else
                                cmd.push_first = 1'b1;
                        end
                        OP_PUSH_SECOND:
                        begin
                            cmd.load = 1'b1;
                            if (stat.full)
                                cmd.resp_status = ST_FULL;
                            else
                                cmd.push_second = 1'b1;
                        end
                        OP_POP_FIRST:
                        begin
                            if (stat.first_empty)
                            begin
                                cmd.load        = 1'b1;
                                cmd.resp_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_first = 1'b1;
                                state_next    = S_POP_DATA;
                            end
                        end
                        OP_POP_SECOND:
                        begin
                            if (stat.second_empty)
                            begin
                                cmd.load        = 1'b1;
                                cmd.resp_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.pop_second = 1'b1;
                                state_next     = S_POP_DATA;
                            end
                        end
                        OP_LIST_FIRST:
                        begin
                            if (stat.first_empty)
                            begin
                                cmd.load        = 1'b1;
                                cmd.resp_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.list_first = 1'b1;
                                state_next     = S_LIST_DATA;
                            end
                        end
                        OP_LIST_SECOND:
                        begin
                            if (stat.second_empty)
                            begin
                                cmd.load        = 1'b1;
                                cmd.resp_status = ST_EMPTY;
                            end
                            else
                            begin
                                cmd.list_second = 1'b1;
                                state_next      = S_LIST_DATA;
                            end
                        end
                        default:
                        begin
                            // unused codes: no result, no state change
                        end
                    endcase
                end
            end
            S_POP_DATA:
            begin
                if (stat.out_free)
                begin
                    cmd.load     = 1'b1;
                    cmd.resp_mem = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_LIST_DATA:
            begin
                if (stat.out_free)
                begin
                    cmd.load      = 1'b1;
                    cmd.resp_mem  = 1'b1;
                    cmd.resp_last = stat.cursor_end;
                    if (stat.cursor_end)
                        state_next = S_IDLE;
                    else
                        cmd.list_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/tss_dp.sv */
// Datapath for the twin stack shared store unit: shared memory, stack pointers,
// list cursor and result register. Uses tss_pkg.
module tss_dp #(
    parameter int STORE_DEPTH = tss_pkg::STORE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tss_pkg::cmd_t                       cmd,
    output tss_pkg::stat_t                      stat,
    input  logic signed [tss_pkg::DATA_W-1:0]   push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tss_pkg::STATUS_W-1:0]        status,
    output logic signed [tss_pkg::DATA_W-1:0]   element,
    output logic                                last
);
    import tss_pkg::*;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] TOP_ADDR  = ADDR_W'(STORE_DEPTH - 1);

    logic [DATA_W-1:0] mem [STORE_DEPTH];

    logic [CNT_W-1:0]  first_count_reg, first_count_next;
    logic [CNT_W-1:0]  second_base_reg, second_base_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic              dir_down_reg, dir_down_next;
    logic [DATA_W-1:0] rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    status_t           status_reg;
    logic [DATA_W-1:0] element_reg;
    logic              last_reg;

    logic [CNT_W-1:0]  first_top;
    logic [CNT_W-1:0]  second_below;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic              wr_en;

    assign first_top    = first_count_reg - CNT_W'(1);
    assign second_below = second_base_reg - CNT_W'(1);

    // Status toward the controller
    assign stat.full         = (first_count_reg == second_base_reg);
    assign stat.first_empty  = (first_count_reg == '0);
    assign stat.second_empty = (second_base_reg == DEPTH_CNT);
    assign stat.cursor_end   = dir_down_reg ? (cursor_reg == '0) : (cursor_reg == TOP_ADDR);
    assign stat.out_free     = !out_valid_reg || !out_stall;

    // Memory address selection
    assign rd_en = cmd.pop_first || cmd.pop_second || cmd.list_first
                   || cmd.list_second || cmd.list_next;
    assign wr_en = cmd.push_first || cmd.push_second;

    always_comb
    begin
        if (cmd.pop_first || cmd.list_first)
            rd_addr = first_top[ADDR_W-1:0];
        else if (cmd.list_next)
            rd_addr = dir_down_reg ? (cursor_reg - ADDR_W'(1)) : (cursor_reg + ADDR_W'(1));
        else
            rd_addr = second_base_reg[ADDR_W-1:0];
    end

    assign wr_addr = cmd.push_first ? first_count_reg[ADDR_W-1:0]
                                    : second_below[ADDR_W-1:0];

    // Shared store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= push_value;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    // Pointer and cursor updates
    always_comb
    begin
        first_count_next = first_count_reg;
        second_base_next = second_base_reg;
        cursor_next      = cursor_reg;
        dir_down_next    = dir_down_reg;
        if (cmd.push_first)
            first_count_next = first_count_reg + CNT_W'(1);
        if (cmd.pop_first)
            first_count_next = first_top;
        if (cmd.push_second)
            second_base_next = second_below;
        if (cmd.pop_second)
            second_base_next = second_base_reg + CNT_W'(1);
        if (cmd.list_first || cmd.list_second || cmd.list_next)
            cursor_next = rd_addr;
        if (cmd.list_first)
            dir_down_next = 1'b1;
        if (cmd.list_second)
            dir_down_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_count_reg <= '0;
            second_base_reg <= DEPTH_CNT;
            cursor_reg      <= '0;
            dir_down_reg    <= 1'b0;
        end
        else
        begin
            first_count_reg <= first_count_next;
            second_base_reg <= second_base_next;
            cursor_reg      <= cursor_next;
            dir_down_reg    <= dir_down_next;
        end
    end

    // Result register
    always_comb
    begin
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            status_reg  <= cmd.resp_status;
            element_reg <= cmd.resp_mem ? rd_data_reg : '0;
            last_reg    <= cmd.resp_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign last      = last_reg;

endmodule

/* rtl/twin_stack_shared_store_unit.sv */
// Twin stack shared store unit: two LIFO stacks in one memory, first grows up, second down.
// Push: result in the cycle after accept; next item the following cycle if no output stall.
// Pop: element via a read register (registered memory read) to the result register, and no
// new item until then. List: elements one per cycle if no output stall, read port bound.
// Reset clears stack pointers and control; memory contents undefined until pushed.
// Depends on tss_pkg, tss_ctrl, tss_dp.
module twin_stack_shared_store_unit #(
    parameter int STORE_DEPTH = tss_pkg::STORE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tss_pkg::OP_W-1:0]            operation,
    input  logic signed [tss_pkg::DATA_W-1:0]   push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tss_pkg::STATUS_W-1:0]        status,
    output logic signed [tss_pkg::DATA_W-1:0]   element,
    output logic                                last
);
    import tss_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd)
    );

    tss_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .element    (element),
        .last       (last)
    );

    // Full and empty results are single and carry no element
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL || status == ST_EMPTY)) |-> (last && element == '0))
        else $error("full/empty result not single or element nonzero");

    // Only list elements can be non-final, and they are always ok
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (status == ST_OK))
        else $error("non-final result with error status");

    // A list streams without gaps once a non-final element is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last) |=> out_valid)
        else $error("gap in list stream");

    // No new item enters while a list is still being emitted
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> in_stall)
        else $error("item accepted during list");

endmodule

/* test/twin_stack_shared_store_checker.sv */
// Checker for the twin stack shared store unit: watches both channels, keeps its own
// copy of the two stacks, predicts every result and compares them in order.
// Depends on tss_pkg.
module twin_stack_shared_store_checker #(
    parameter int DEPTH = tss_pkg::STORE_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic [tss_pkg::OP_W-1:0]            operation,
    input  logic signed [tss_pkg::DATA_W-1:0]   push_value,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [tss_pkg::STATUS_W-1:0]        status,
    input  logic signed [tss_pkg::DATA_W-1:0]   element,
    input  logic                                last,
    output int                                  fail_count,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  element;
        logic                      last;
    } stack_result_t;

    // Shadow copy of the shared store and both stack pointers
    logic signed [DATA_W-1:0] shadow_store [DEPTH];
    int                       first_fill;
    int                       second_top;

    stack_result_t            pending_results [$];
    int                       mismatch_total;

    function automatic stack_result_t make_result(input status_t st,
                                                  input logic signed [DATA_W-1:0] elem,
                                                  input logic is_last);
        stack_result_t r;
        r.status  = st;
        r.element = elem;
        r.last    = is_last;
        return r;
    endfunction

    // Apply one accepted item to the shadow state and queue what it should produce
    task automatic predict_stack_op(input logic [OP_W-1:0] op,
                                    input logic signed [DATA_W-1:0] value);
        case (op)
            OP_PUSH_FIRST, OP_PUSH_SECOND:
            begin
                if (first_fill >= second_top) begin
                    pending_results.push_back(make_result(ST_FULL, '0, 1'b1));
                end
                else begin
                    if (op == OP_PUSH_FIRST) begin
                        shadow_store[first_fill] = value;
                        first_fill++;
                    end
                    else begin
                        second_top--;
                        shadow_store[second_top] = value;
                    end
                    pending_results.push_back(make_result(ST_OK, '0, 1'b1));
                end
            end
            OP_POP_FIRST:
            begin
                if (first_fill == 0) begin
                    pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end
                else begin
                    first_fill--;
                    pending_results.push_back(make_result(ST_OK, shadow_store[first_fill],
                                                          1'b1));
                end
            end
            OP_POP_SECOND:
            begin
                if (second_top >= DEPTH) begin
                    pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end
                else begin
                    pending_results.push_back(make_result(ST_OK, shadow_store[second_top],
                                                          1'b1));
                    second_top++;
                end
            end
            OP_LIST_FIRST:
            begin
                if (first_fill == 0) begin
                    pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end
                else begin
                    // top of the first stack down to index 0
                    for (int i = first_fill; i > 0; i--) begin
                        pending_results.push_back(make_result(ST_OK, shadow_store[i-1],
                                                              i == 1));
                    end
                end
            end
            OP_LIST_SECOND:
            begin
                if (second_top >= DEPTH) begin
                    pending_results.push_back(make_result(ST_EMPTY, '0, 1'b1));
                end
                else begin
                    // top of the second stack up to the high end
                    for (int i = second_top; i < DEPTH; i++) begin
                        pending_results.push_back(make_result(ST_OK, shadow_store[i],
                                                              i == DEPTH - 1));
                    end
                end
            end
            default:
            begin
                // unused codes: no result, no state change
            end
        endcase
    endtask

    // Compare one accepted result against the oldest expectation
    task automatic compare_result();
        stack_result_t want;
        if (pending_results.size() == 0) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_MAX)
                $display("%0t: unexpected result: status %0d element %0d last %0b",
                         $time, status, element, last);
        end
        else begin
            want = pending_results.pop_front();
            if (status !== want.status || element !== want.element || last !== want.last)
            begin
                mismatch_total++;
                if (mismatch_total <= REPORT_MAX)
                    $display({"%0t: mismatch: expected status %0d element %0d last %0b,",
                              " got status %0d element %0d last %0b"},
                             $time, want.status, want.element, want.last,
                             status, element, last);
            end
        end
    endtask

    // Results first: anything leaving now belongs to an item accepted earlier
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pending_results.delete();
            for (int i = 0; i < DEPTH; i++)
                shadow_store[i] = '0;
            first_fill     = 0;
            second_top     = DEPTH;
            mismatch_total = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else begin
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall)
                predict_stack_op(operation, push_value);
            fail_count  <= mismatch_total;
            outstanding <= pending_results.size();
        end
    end

endmodule

/* test/twin_stack_shared_store_unit_tb.sv */
// Top of the twin stack shared store unit testbench: clock, reset, item stimulus with
// random idling on both sides, a watchdog and the verdict.
// Depends on tss_pkg, twin_stack_shared_store_unit and twin_stack_shared_store_checker.
module twin_stack_shared_store_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int DEPTH          = STORE_DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 165;
    localparam int QUIET_ITEMS    = 30;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 2 * DEPTH + 8;
    localparam int WATCHDOG_LIMIT = 2000;

    // codes outside the defined operation set
    localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

    // random mix of operations per block of items
    localparam int MIX_BALANCED = 0;
    localparam int MIX_FILL     = 1;
    localparam int MIX_DRAIN    = 2;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic [OP_W-1:0]             operation  = '0;
    logic signed [DATA_W-1:0]    push_value = '0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic [STATUS_W-1:0]         status;
    logic signed [DATA_W-1:0]    element;
    logic                        last;

    int   fail_count;
    int   outstanding;

    logic quiet         = 1'b0;
    int   hold_req_cnt  = 0;
    int   hold_seen_cnt = 0;
    int   hold_left     = 0;
    int   stall_left    = 0;
    int   calm_left     = 0;
    int   send_calm     = 0;
    int   idle_cycles   = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    twin_stack_shared_store_unit #(.STORE_DEPTH(DEPTH)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .element    (element),
        .last       (last)
    );

    twin_stack_shared_store_checker #(.DEPTH(DEPTH)) result_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .push_value  (push_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .element     (element),
        .last        (last),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Watchdog: too long without any item moving on either channel
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stall bursts, calm stretches, one long hold-off on request
    initial begin
        int pick;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req_cnt != hold_seen_cnt) begin
                hold_seen_cnt = hold_req_cnt;
                hold_left     = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else if (quiet) begin
                out_stall <= 1'b0;
            end
            else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (calm_left > 0) begin
                calm_left--;
                out_stall <= 1'b0;
            end
            else begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    stall_left = $urandom_range(0, 10);
                    out_stall <= 1'b1;
                end
                else if (pick == 2) begin
                    calm_left = $urandom_range(15, 50);
                    out_stall <= 1'b0;
                end
                else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Offer one item, possibly after an idle gap, and hold it until accepted
    task automatic offer_item(input logic [OP_W-1:0] op,
                              input logic signed [DATA_W-1:0] value);
        int gap;
        gap = 0;
        if (!quiet) begin
            if (send_calm > 0)
                send_calm--;
            else if ($urandom_range(0, 7) == 0)
                send_calm = $urandom_range(8, 30);
            else if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 11);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        push_value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // Stop sending until every expected result is back, then let the block settle
    task automatic wait_all_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return ($urandom_range(0, 1) != 0) ? -32'sd1 : 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_op(input int mix);
        int r;
        int push_w;
        int pop_w;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_w = 70; pop_w = 17; end
            MIX_DRAIN: begin push_w = 20; pop_w = 60; end
            default:   begin push_w = 40; pop_w = 36; end
        endcase
        if (r < 3)
            return ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
        else if (r < 3 + push_w)
            return ($urandom_range(0, 1) != 0) ? OP_PUSH_SECOND : OP_PUSH_FIRST;
        else if (r < 3 + push_w + pop_w)
            return ($urandom_range(0, 1) != 0) ? OP_POP_SECOND : OP_POP_FIRST;
        else
            return ($urandom_range(0, 1) != 0) ? OP_LIST_SECOND : OP_LIST_FIRST;
    endfunction

    // Stimulus
    initial begin
        int               counted;
        int               block_left;
        int               mix;
        logic [OP_W-1:0]  op;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty stacks and the unused codes
        offer_item(OP_POP_FIRST, 32'sd5);
        offer_item(OP_POP_SECOND, -32'sd5);
        offer_item(OP_LIST_FIRST, 32'sd0);
        offer_item(OP_LIST_SECOND, 32'sd0);
        offer_item(OP_UNUSED_LO, 32'sd1);
        offer_item(OP_UNUSED_HI, -32'sd1);

        // fill the store from both ends, extremes first
        offer_item(OP_PUSH_FIRST, 32'sh7FFF_FFFF);
        offer_item(OP_PUSH_SECOND, 32'sh8000_0000);
        for (int i = 0; i < DEPTH - 2; i++)
            offer_item((i % 3 == 0) ? OP_PUSH_SECOND : OP_PUSH_FIRST, pick_value());

        // no free slot left: both pushes refused
        offer_item(OP_PUSH_FIRST, 32'sd1);
        offer_item(OP_PUSH_SECOND, 32'sd2);

        // full lists, then a pop from each side
        offer_item(OP_LIST_FIRST, 32'sd0);
        offer_item(OP_LIST_SECOND, 32'sd0);
        offer_item(OP_POP_FIRST, 32'sd0);
        offer_item(OP_POP_SECOND, 32'sd0);
        wait_all_results();

        // result side holds off while lists and pushes keep coming
        hold_req_cnt <= hold_req_cnt + 1;
        for (int i = 0; i < 24; i++)
            offer_item((i % 4 == 3) ? OP_PUSH_FIRST
                       : ((i % 2 == 0) ? OP_LIST_FIRST : OP_LIST_SECOND), pick_value());
        wait_all_results();

        // random part in blocks of mixed flavor
        counted    = 0;
        block_left = 0;
        mix        = MIX_BALANCED;
        while (counted < RANDOM_ITEMS) begin
            if (block_left == 0) begin
                mix        = $urandom_range(MIX_BALANCED, MIX_DRAIN);
                block_left = $urandom_range(12, 30);
            end
            if (counted >= RANDOM_ITEMS - QUIET_ITEMS && !quiet)
                quiet <= 1'b1;
            op = pick_op(mix);
            offer_item(op, pick_value());
            if (op <= OP_LIST_SECOND) begin
                counted++;
                block_left--;
            end
        end
        wait_all_results();

        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* twin_stack_shared_store_unit.f */
rtl/tss_pkg.sv
rtl/tss_ctrl.sv
rtl/tss_dp.sv
rtl/twin_stack_shared_store_unit.sv
test/twin_stack_shared_store_checker.sv
test/twin_stack_shared_store_unit_tb.sv
